// ----- design/rlcv_pkg.sv -----
// Shared types, codes and command schedules of the RLC velocity Verlet integrator.
`default_nettype none

package rlcv_pkg;

  // Data path widths.
  localparam int DW     = 32;      // signed fixed point word
  localparam int TW     = 31;      // time and time step word
  localparam int AW     = DW + 2;  // multiplier A operand, holds the unsaturated sum of two words
  localparam int SW     = DW + 3;  // widest sum before saturation
  localparam int IDX_W  = 3;       // configuration register index
  localparam int CNT_W  = 5;       // schedule counter

  typedef logic signed [DW-1:0] data_t;
  typedef logic [DW-1:0]        coef_t;
  typedef logic [TW-1:0]        time_t;
  typedef logic [IDX_W-1:0]     reg_idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // Configuration register indexes.
  localparam reg_idx_t REG_MODE    = 3'd0;
  localparam reg_idx_t REG_DAMP    = 3'd1;
  localparam reg_idx_t REG_STIFF   = 3'd2;
  localparam reg_idx_t REG_DT      = 3'd3;
  localparam reg_idx_t REG_RES     = 3'd4;
  localparam reg_idx_t REG_REACT   = 3'd5;
  localparam reg_idx_t REG_INV     = 3'd6;
  localparam reg_idx_t REG_END     = 3'd7;

  // Configuration reset values.
  localparam time_t DT_RESET  = 31'd65;
  localparam time_t END_RESET = 31'h7FFF_FFFF;

  // Input item actions and circuit modes.
  localparam logic ACT_LOAD      = 1'b0;
  localparam logic ACT_STEP      = 1'b1;
  localparam logic MODE_SERIES   = 1'b0;
  localparam logic MODE_PARALLEL = 1'b1;

  // Multiplier A operand sources (signed).
  typedef logic [3:0] asel_t;
  localparam asel_t A_Y    = 4'd0;
  localparam asel_t A_DY   = 4'd1;
  localparam asel_t A_DT   = 4'd2;
  localparam asel_t A_A0   = 4'd3;
  localparam asel_t A_TMP  = 4'd4;
  localparam asel_t A_ASUM = 4'd5;
  localparam asel_t A_DY1  = 4'd6;
  localparam asel_t A_YF   = 4'd7;
  localparam asel_t A_LSUM = 4'd8;

  // Multiplier B operand sources (unsigned).
  typedef logic [2:0] bsel_t;
  localparam bsel_t B_DT    = 3'd0;
  localparam bsel_t B_DAMP  = 3'd1;
  localparam bsel_t B_STIFF = 3'd2;
  localparam bsel_t B_RES   = 3'd3;
  localparam bsel_t B_REACT = 3'd4;
  localparam bsel_t B_INV   = 3'd5;
  localparam bsel_t B_DTSQ  = 3'd6;
  localparam bsel_t B_HALF  = 3'd7;

  // Destinations of a rounded product.
  typedef logic [3:0] dst_t;
  localparam dst_t D_NONE   = 4'd0;
  localparam dst_t D_DTSQ   = 4'd1;
  localparam dst_t D_QD     = 4'd2;
  localparam dst_t D_QS     = 4'd3;
  localparam dst_t D_YDT    = 4'd4;
  localparam dst_t D_P1     = 4'd5;
  localparam dst_t D_P2     = 4'd6;
  localparam dst_t D_TMP    = 4'd7;
  localparam dst_t D_HQ     = 4'd8;
  localparam dst_t D_DYDT   = 4'd9;
  localparam dst_t D_SLOPEN = 4'd10;

  // Adder operations.
  typedef logic [2:0] alu_t;
  localparam alu_t ALU_NONE   = 3'd0;
  localparam alu_t ALU_A0     = 3'd1;
  localparam alu_t ALU_DY1    = 3'd2;
  localparam alu_t ALU_YF     = 3'd3;
  localparam alu_t ALU_ASUM   = 3'd4;
  localparam alu_t ALU_LSUM   = 3'd5;
  localparam alu_t ALU_COMMIT = 3'd6;
  localparam alu_t ALU_FIN    = 3'd7;

  // Command from the controller to the datapath for one cycle.
  typedef struct packed {
    logic  capture;
    logic  mul_en;
    asel_t a_sel;
    bsel_t b_sel;
    dst_t  dst;
    alu_t  alu;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic finished;
  } status_t;

  localparam cmd_t CMD_NOP = '{capture: 1'b0, mul_en: 1'b0, a_sel: A_Y, b_sel: B_DT,
                               dst: D_NONE, alu: ALU_NONE};

  // Last schedule slot of each sequence.
  localparam cnt_t LOAD_LAST = 5'd4;
  localparam cnt_t STEP_LAST = 5'd16;

  // Saturate a wide signed sum to the data word.
  function automatic data_t sat_dw(input logic signed [SW-1:0] v);
    logic fits;
    fits = (v[SW-1:DW-1] == '0) || (v[SW-1:DW-1] == '1);
    if (fits) begin
      return v[DW-1:0];
    end
    return v[SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
  endfunction

  // A multiplication issue with an optional adder operation in the same cycle.
  function automatic cmd_t mul_op(input asel_t a, input bsel_t b, input dst_t d, input alu_t op);
    cmd_t c;
    c        = CMD_NOP;
    c.mul_en = 1'b1;
    c.a_sel  = a;
    c.b_sel  = b;
    c.dst    = d;
    c.alu    = op;
    return c;
  endfunction

  function automatic cmd_t alu_op(input alu_t op);
    cmd_t c;
    c     = CMD_NOP;
    c.alu = op;
    return c;
  endfunction

  // Load sequence: slope = -sat(base*R + other) * inverse reactive coefficient.
  function automatic cmd_t load_cmd(input cnt_t idx);
    cmd_t c;
    case (idx)
      5'd0:    c = mul_op(A_Y, B_RES, D_TMP, ALU_NONE);
      5'd2:    c = alu_op(ALU_LSUM);
      5'd3:    c = mul_op(A_LSUM, B_INV, D_SLOPEN, ALU_NONE);
      default: c = CMD_NOP;
    endcase
    return c;
  endfunction

  // Step sequence. A product passes the product register before it reaches its destination.
  function automatic cmd_t step_cmd(input cnt_t idx);
    cmd_t c;
    case (idx)
      5'd0:    c = mul_op(A_DT,   B_DT,    D_DTSQ, ALU_NONE);
      5'd1:    c = mul_op(A_DY,   B_DAMP,  D_QD,   ALU_NONE);
      5'd2:    c = mul_op(A_Y,    B_STIFF, D_QS,   ALU_NONE);
      5'd3:    c = mul_op(A_DY,   B_DT,    D_YDT,  ALU_NONE);
      5'd4:    c = mul_op(A_Y,    B_RES,   D_P1,   ALU_A0);
      5'd5:    c = mul_op(A_A0,   B_DTSQ,  D_TMP,  ALU_NONE);
      5'd6:    c = mul_op(A_A0,   B_DT,    D_DYDT, ALU_NONE);
      5'd7:    c = mul_op(A_TMP,  B_HALF,  D_HQ,   ALU_NONE);
      5'd8:    c = mul_op(A_DY,   B_REACT, D_P2,   ALU_DY1);
      5'd9:    c = mul_op(A_DY1,  B_DAMP,  D_QD,   ALU_YF);
      5'd10:   c = mul_op(A_YF,   B_STIFF, D_QS,   ALU_NONE);
      5'd12:   c = alu_op(ALU_ASUM);
      5'd13:   c = mul_op(A_ASUM, B_DT,    D_TMP,  ALU_NONE);
      5'd15:   c = mul_op(A_TMP,  B_HALF,  D_HQ,   ALU_NONE);
      default: c = CMD_NOP;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- design/rlcv_item_if.sv -----
// Input channel of the integrator: handshake and one input item.
`default_nettype none

interface rlcv_item_if import rlcv_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  action;
  data_t initial_current;
  data_t initial_voltage;

  modport source (output valid, action, initial_current, initial_voltage, input ready);
  modport sink (input valid, action, initial_current, initial_voltage, output ready);
endinterface

`default_nettype wire

// ----- design/rlcv_result_if.sv -----
// Output channel of the integrator: handshake and one result item.
`default_nettype none

interface rlcv_result_if import rlcv_pkg::*; ();
  logic  valid;
  logic  ready;
  time_t sim_time;
  data_t state_value;
  data_t resistor_part;
  data_t reactive_part;
  data_t remaining_part;
  logic  finished;

  modport source (output valid, sim_time, state_value, resistor_part, reactive_part,
                  remaining_part, finished, input ready);
  modport sink (input valid, sim_time, state_value, resistor_part, reactive_part,
                remaining_part, finished, output ready);
endinterface

`default_nettype wire

// ----- design/rlcv_ctrl.sv -----
// Controller: sequences the load and step schedules and owns the result valid flag.
`default_nettype none

module rlcv_ctrl import rlcv_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_action,
  output logic    item_ready,
  output logic    result_valid,
  input  logic    result_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_STEP = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state, state_next;
  cnt_t       cnt, cnt_next;
  logic       out_valid, out_valid_next;
  logic       out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free     = !out_valid || result_ready;
  assign result_valid = out_valid;

  // Next state and command decode.
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cmd            = CMD_NOP;
    item_ready     = 1'b0;
    out_valid_next = out_valid && !result_ready;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cnt_next = '0;
          if (item_action == ACT_LOAD) begin
            cmd.capture = 1'b1;
            state_next  = S_LOAD;
          end else if (status.finished) begin
            state_next = S_FIN;
          end else begin
            state_next = S_STEP;
          end
        end
      end
      S_LOAD: begin
        cmd = load_cmd(cnt);
        if (cnt == LOAD_LAST) begin
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      S_STEP: begin
        cmd = step_cmd(cnt);
        if (cnt == STEP_LAST) begin
          state_next = S_DONE;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.alu        = ALU_COMMIT;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.alu        = ALU_FIN;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/rlcv_dpath.sv -----
// Datapath: configuration registers, state, one shared rounding multiplier and the adders.
`default_nettype none

module rlcv_dpath import rlcv_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_we,
  input  reg_idx_t cfg_index,
  input  coef_t    cfg_data,
  input  data_t    initial_current,
  input  data_t    initial_voltage,
  input  cmd_t     cmd,
  output status_t  status,
  output time_t    sim_time,
  output data_t    state_value,
  output data_t    resistor_part,
  output data_t    reactive_part,
  output data_t    remaining_part,
  output logic     finished
);

  localparam int PW = 2 * DW + 1;
  localparam logic [PW:0]   ROUND_ONE = (PW + 1)'(1) << (FRAC_BITS - 1);
  localparam coef_t         HALF      = DW'(1) << (FRAC_BITS - 1);
  localparam coef_t         POS_MAX   = {1'b0, {(DW-1){1'b1}}};

  // Configuration.
  logic  mode;
  coef_t damp, stiff, res, react, inv;
  time_t dt, tend;

  // Integrator state and intermediate results.
  data_t value, slope;
  time_t tnow;
  data_t other, dtsq, qd, qs, ydt, p1, p2, tmp, hq, dydt, a0, dy1, yf, lsum;
  logic signed [DW:0] asum;

  // Multiplier pipeline.
  logic signed [AW-1:0] a_op, a_abs;
  coef_t                b_op;
  logic [DW:0]          mag;
  logic [PW-1:0]        prod;
  logic                 prod_neg;
  dst_t                 prod_dst;

  // Rounding and saturation of the registered product.
  logic [PW:0] rsum, rshift;
  coef_t       lim, rmag;
  data_t       q;

  // Sums.
  logic signed [SW-1:0] accel_sum;
  logic [TW:0]          tsum;

  assign status.finished = tnow > tend;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_SERIES;
      damp  <= '0;
      stiff <= '0;
      dt    <= DT_RESET;
      res   <= '0;
      react <= '0;
      inv   <= '0;
      tend  <= END_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:  mode  <= cfg_data[0];
        REG_DAMP:  damp  <= cfg_data;
        REG_STIFF: stiff <= cfg_data;
        REG_DT:    dt    <= cfg_data[TW-1:0];
        REG_RES:   res   <= cfg_data;
        REG_REACT: react <= cfg_data;
        REG_INV:   inv   <= cfg_data;
        REG_END:   tend  <= cfg_data[TW-1:0];
        default:   ;
      endcase
    end
  end

  // Operand selection.
  always_comb begin
    case (cmd.a_sel)
      A_Y:     a_op = AW'(value);
      A_DY:    a_op = AW'(slope);
      A_DT:    a_op = AW'($signed({1'b0, dt}));
      A_A0:    a_op = AW'(a0);
      A_TMP:   a_op = AW'(tmp);
      A_ASUM:  a_op = AW'(asum);
      A_DY1:   a_op = AW'(dy1);
      A_YF:    a_op = AW'(yf);
      A_LSUM:  a_op = AW'(lsum);
      default: a_op = '0;
    endcase
    case (cmd.b_sel)
      B_DT:    b_op = DW'(dt);
      B_DAMP:  b_op = damp;
      B_STIFF: b_op = stiff;
      B_RES:   b_op = res;
      B_REACT: b_op = react;
      B_INV:   b_op = inv;
      B_DTSQ:  b_op = coef_t'(dtsq);
      B_HALF:  b_op = HALF;
      default: b_op = '0;
    endcase
    a_abs = a_op[AW-1] ? -a_op : a_op;
    mag   = a_abs[DW:0];
  end

  // Magnitude product, registered with its sign and destination.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_dst <= D_NONE;
    end else begin
      prod_dst <= cmd.mul_en ? cmd.dst : D_NONE;
    end
    prod     <= mag * b_op;
    prod_neg <= a_op[AW-1];
  end

  // Round to nearest with ties away from zero, then saturate and restore the sign.
  always_comb begin
    rsum   = {1'b0, prod} + ROUND_ONE;
    rshift = rsum >> FRAC_BITS;
    lim    = POS_MAX + DW'(prod_neg);
    rmag   = (rshift > (PW + 1)'(lim)) ? lim : rshift[DW-1:0];
    q      = prod_neg ? -data_t'(rmag) : data_t'(rmag);
  end

  // Acceleration -damping*dy - stiffness*y from the two latest products.
  assign accel_sum = -SW'(qd) - SW'(qs);
  assign tsum      = {1'b0, tnow} + {1'b0, dt};

  // Product write-back, adder operations, load capture and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      value       <= '0;
      slope       <= '0;
      tnow        <= '0;
    end else begin
      case (prod_dst)
        D_DTSQ:   dtsq  <= q;
        D_QD:     qd    <= q;
        D_QS:     qs    <= q;
        D_YDT:    ydt   <= q;
        D_P1:     p1    <= q;
        D_P2:     p2    <= q;
        D_TMP:    tmp   <= q;
        D_HQ:     hq    <= q;
        D_DYDT:   dydt  <= q;
        D_SLOPEN: slope <= sat_dw(-SW'(q));
        default:  ;
      endcase

      if (cmd.capture) begin
        value <= (mode == MODE_PARALLEL) ? initial_voltage : initial_current;
        other <= (mode == MODE_PARALLEL) ? initial_current : initial_voltage;
        tnow  <= '0;
      end

      case (cmd.alu)
        ALU_A0:   a0   <= sat_dw(accel_sum);
        ALU_DY1:  dy1  <= sat_dw(SW'(slope) + SW'(dydt));
        ALU_YF:   yf   <= sat_dw(SW'(value) + SW'(ydt) + SW'(hq));
        ALU_ASUM: asum <= (DW + 1)'(a0) + (DW + 1)'(sat_dw(accel_sum));
        ALU_LSUM: lsum <= sat_dw(SW'(tmp) + SW'(other));
        ALU_COMMIT: begin
          value          <= yf;
          slope          <= sat_dw(SW'(slope) + SW'(hq));
          tnow           <= tsum[TW] ? {TW{1'b1}} : tsum[TW-1:0];
          sim_time       <= tnow;
          state_value    <= yf;
          resistor_part  <= p1;
          reactive_part  <= p2;
          remaining_part <= sat_dw(-(SW'(p1) + SW'(p2)));
          finished       <= 1'b0;
        end
        ALU_FIN: begin
          sim_time       <= tnow;
          state_value    <= value;
          resistor_part  <= '0;
          reactive_part  <= '0;
          remaining_part <= '0;
          finished       <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/rlc_velocity_verlet_step_core.sv -----
// Top level of the RLC velocity Verlet integrator: controller, datapath and channel wiring.
// A load item captures its initial values and runs the load schedule; it gives no result.
// A step item runs the step schedule of thirteen products on one shared multiplier, whose
// product is registered and then rounded, and writes its result once the output register is
// free; no item is taken before then. A step after the end time writes a finished result.
// Synchronous active-high reset zeroes value, slope and time and restores configuration defaults.
`default_nettype none

module rlc_velocity_verlet_step_core import rlcv_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  reg_idx_t        cfg_index,
  input  coef_t           cfg_data,
  rlcv_item_if.sink       item,
  rlcv_result_if.source   result
);

  cmd_t    cmd;
  status_t status;

  // Sequencing of load and step schedules.
  rlcv_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_action  (item.action),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .status       (status),
    .cmd          (cmd)
  );

  // Arithmetic, state and result register.
  rlcv_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .initial_current (item.initial_current),
    .initial_voltage (item.initial_voltage),
    .cmd             (cmd),
    .status          (status),
    .sim_time        (result.sim_time),
    .state_value     (result.state_value),
    .resistor_part   (result.resistor_part),
    .reactive_part   (result.reactive_part),
    .remaining_part  (result.remaining_part),
    .finished        (result.finished)
  );

  // The multiplier is only fed while no item can be taken.
  assert property (@(posedge clk) disable iff (rst) cmd.mul_en |-> !item.ready)
    else $error("multiplier issued while the input was ready");

  // Load values are captured only on the transfer of a load item.
  assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> (item.valid && item.ready && item.action == ACT_LOAD))
    else $error("capture without a load transfer");

  // Writing a result always leaves it valid in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.alu == ALU_COMMIT || cmd.alu == ALU_FIN) |=> result.valid)
    else $error("result written but not presented");

  // A finished result carries no component parts.
  assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.finished) |->
      (result.resistor_part == '0 && result.reactive_part == '0 &&
       result.remaining_part == '0))
    else $error("finished result with non-zero parts");

endmodule

`default_nettype wire
